/* design/fsja_pkg.sv */
// ----------------------------------------------------------------------------
// fsja_pkg
// shared types and constants for the fair-share job admission core
// ----------------------------------------------------------------------------
package fsja_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned HOST_W  = 32;
  localparam int unsigned RAND_W  = 31;
  localparam int unsigned CAUSE_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HLEN_W  = 7;
  localparam int unsigned PROD_W  = TIME_W + RAND_W;

  // random word value that stands for a probability of one
  localparam logic [RAND_W-1:0] RATIO_ONE = {RAND_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_CHECK   = 2'd0,
    FUNC_RECORD  = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_RAND_REJECT = 3'd0,
    CAUSE_DISABLED    = 3'd1,
    CAUSE_MASTER      = 3'd2,
    CAUSE_ZERO_TIME   = 3'd3,
    CAUSE_REPEAT_HOST = 3'd4,
    CAUSE_WINDOW      = 3'd5,
    CAUSE_RAND_ACCEPT = 3'd6
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_ENABLED   = 3'd0,
    CFG_MASTER_MODE    = 3'd1,
    CFG_REPEAT_LIMIT   = 3'd2,
    CFG_WINDOW_SECONDS = 3'd3,
    CFG_HISTORY_LENGTH = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WIDEN,
    ST_EVAL,
    ST_DONE
  } state_t;

  localparam logic [7:0]  REPEAT_LIMIT_RST   = 8'd8;
  localparam logic [15:0] WINDOW_SECONDS_RST = 16'd60;
  localparam logic [HLEN_W-1:0] HISTORY_LEN_RST = 7'd64;

endpackage

/* design/fair_share_job_admission_core.sv */
// ----------------------------------------------------------------------------
// fair_share_job_admission_core
// admission gate for job requests with a fair-share random compare
// ----------------------------------------------------------------------------
// Takes one item per input transfer: check a request, record a job time,
// restart the window, or a one-second tick. Only a check produces a result
// transfer. Record, restart and tick leave the core idle. A check settled
// by a shortcut (gate off, master mode, zero time, repeat host, window
// elapsed) goes from acceptance to the done state. A check that falls
// through to the random compare walks the running minimum down the row of
// history cells one cell per cycle in the scan state; then the widen state
// forms the scaled baseline and the product, the eval state compares, and
// the done state loads the output register once it is free. A finished
// result waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
module fair_share_job_admission_core #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [fsja_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsja_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic [fsja_pkg::TIME_W-1:0]         in_job_time,
  input  logic [fsja_pkg::HOST_W-1:0]         in_host_id,
  input  logic [fsja_pkg::RAND_W-1:0]         in_random_word,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_accept,
  output logic [fsja_pkg::CAUSE_W-1:0]        out_decision_cause
);

  localparam int unsigned SCW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [SCW-1:0] SCAN_LAST = SCW'(HISTORY_DEPTH - 1);

  // configuration registers
  logic                               gate_r;
  logic                               master_r;
  logic [7:0]                         limit_r;
  logic [15:0]                        window_r;
  logic [fsja_pkg::HLEN_W-1:0]        hist_len_r;

  // tracking state
  logic [fsja_pkg::HOST_W-1:0]        last_host_r;
  logic [7:0]                         repeat_cnt_r;
  logic [fsja_pkg::TIME_W-1:0]        elapsed_r;

  // check in flight
  fsja_pkg::state_t                   state_r, state_nxt;
  logic [SCW-1:0]                     scan_cnt_r;
  logic [fsja_pkg::TIME_W-1:0]        t_r;
  logic [fsja_pkg::RAND_W-1:0]        rw_r;
  logic [fsja_pkg::TIME_W-1:0]        base_r;
  logic [fsja_pkg::PROD_W-1:0]        prod_r;
  logic [fsja_pkg::PROD_W-1:0]        lhs_r;
  logic                               res_accept_r;
  fsja_pkg::cause_t                   res_cause_r;

  // output register
  logic                               out_valid_r;
  logic                               out_accept_r;
  fsja_pkg::cause_t                   out_cause_r;

  logic [fsja_pkg::TIME_W-1:0]        chain_min;
  fsja_pkg::func_t                    func;
  logic                               in_xfer;
  logic                               is_check;
  logic                               is_record;
  logic                               out_free;
  logic                               track_upd;
  logic [7:0]                         repeat_inc;
  logic                               short_hit;
  fsja_pkg::cause_t                   short_cause;
  logic                               eval_accept;

  // per-state controls
  logic                               idle_st;
  logic                               scan_st;
  logic                               widen_st;
  logic                               eval_st;
  logic                               done_st;

  assign func      = fsja_pkg::func_t'(in_func);
  assign in_xfer   = in_valid && !in_stall;
  assign is_check  = in_xfer && (func == fsja_pkg::FUNC_CHECK);
  assign is_record = in_xfer && (func == fsja_pkg::FUNC_RECORD);
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r     <= 1'b0;
      master_r   <= 1'b0;
      limit_r    <= fsja_pkg::REPEAT_LIMIT_RST;
      window_r   <= fsja_pkg::WINDOW_SECONDS_RST;
      hist_len_r <= fsja_pkg::HISTORY_LEN_RST;
    end else if (cfg_we) begin
      unique case (fsja_pkg::cfg_idx_t'(cfg_index))
        fsja_pkg::CFG_GATE_ENABLED:   gate_r     <= cfg_wdata[0];
        fsja_pkg::CFG_MASTER_MODE:    master_r   <= cfg_wdata[0];
        fsja_pkg::CFG_REPEAT_LIMIT:   limit_r    <= cfg_wdata[7:0];
        fsja_pkg::CFG_WINDOW_SECONDS: window_r   <= cfg_wdata;
        fsja_pkg::CFG_HISTORY_LENGTH: hist_len_r <= cfg_wdata[fsja_pkg::HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shortcut decisions, all settled in the acceptance cycle
  // ---------------------------------------------------------------------------
  // repeat count as it stands after this request (saturating)
  assign repeat_inc = (last_host_r != in_host_id) ? 8'd0 :
                      ((repeat_cnt_r == 8'hFF) ? repeat_cnt_r : (repeat_cnt_r + 8'd1));

  // host tracking only moves once the first three shortcuts are passed
  assign track_upd = is_check && gate_r && !master_r && (in_job_time != '0);

  always_comb begin
    short_hit   = 1'b1;
    short_cause = fsja_pkg::CAUSE_DISABLED;
    priority if (!gate_r) begin
      short_cause = fsja_pkg::CAUSE_DISABLED;
    end else if (master_r) begin
      short_cause = fsja_pkg::CAUSE_MASTER;
    end else if (in_job_time == '0) begin
      short_cause = fsja_pkg::CAUSE_ZERO_TIME;
    end else if (repeat_inc >= limit_r) begin
      short_cause = fsja_pkg::CAUSE_REPEAT_HOST;
    end else if (elapsed_r >= fsja_pkg::TIME_W'(window_r)) begin
      short_cause = fsja_pkg::CAUSE_WINDOW;
    end else begin
      short_hit   = 1'b0;
    end
  end

  // tracking state: repeat host, window timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_host_r  <= '0;
      repeat_cnt_r <= '0;
      elapsed_r    <= '0;
    end else if (in_xfer && (func == fsja_pkg::FUNC_RESTART)) begin
      last_host_r  <= '0;
      repeat_cnt_r <= '0;
      elapsed_r    <= '0;
    end else if (in_xfer && (func == fsja_pkg::FUNC_TICK)) begin
      if (elapsed_r != {fsja_pkg::TIME_W{1'b1}}) begin
        elapsed_r <= elapsed_r + fsja_pkg::TIME_W'(1);
      end
    end else if (track_upd) begin
      last_host_r  <= in_host_id;
      // the repeat accept clears the count
      repeat_cnt_r <= (repeat_inc >= limit_r) ? 8'd0 : repeat_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // history cells: record shifts the row, a check walks the minimum down it
  // ---------------------------------------------------------------------------
  fsja_chain #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_chain (
    .clk            (clk),
    .rst_n          (rst_n),
    .record_en      (is_record),
    .record_time    (in_job_time),
    .history_length (hist_len_r),
    .fallback_time  (t_r),
    .min_out        (chain_min)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsja_pkg::ST_IDLE: begin
        if (is_check) begin
          state_nxt = short_hit ? fsja_pkg::ST_DONE : fsja_pkg::ST_SCAN;
        end
      end
      fsja_pkg::ST_SCAN: begin
        if (scan_cnt_r == SCAN_LAST) begin
          state_nxt = fsja_pkg::ST_WIDEN;
        end
      end
      fsja_pkg::ST_WIDEN: state_nxt = fsja_pkg::ST_EVAL;
      fsja_pkg::ST_EVAL:  state_nxt = fsja_pkg::ST_DONE;
      fsja_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fsja_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fsja_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idle_st  = 1'b0;
    scan_st  = 1'b0;
    widen_st = 1'b0;
    eval_st  = 1'b0;
    done_st  = 1'b0;
    unique case (state_r)
      fsja_pkg::ST_IDLE:  idle_st  = 1'b1;
      fsja_pkg::ST_SCAN:  scan_st  = 1'b1;
      fsja_pkg::ST_WIDEN: widen_st = 1'b1;
      fsja_pkg::ST_EVAL:  eval_st  = 1'b1;
      fsja_pkg::ST_DONE:  done_st  = 1'b1;
      default: ;
    endcase
  end

  // only idle takes new items; a waiting result sits in the output register
  assign in_stall = !idle_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsja_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (idle_st) begin
      scan_cnt_r <= '0;
    end else if (scan_st) begin
      scan_cnt_r <= scan_cnt_r + SCW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // random compare: baseline * ONE > random * time, cross-multiplied
  // ---------------------------------------------------------------------------
  // for job times at or below the baseline the ratio is one or more
  assign eval_accept = (t_r <= base_r) ? (rw_r != fsja_pkg::RATIO_ONE) : (lhs_r > prod_r);

  always_ff @(posedge clk) begin
    if (is_check) begin
      t_r  <= in_job_time;
      rw_r <= in_random_word;
    end
    if (widen_st) begin
      base_r <= chain_min;
      // baseline * (2^31 - 1) as a shift and subtract
      lhs_r  <= {chain_min, {fsja_pkg::RAND_W{1'b0}}} - fsja_pkg::PROD_W'(chain_min);
      prod_r <= fsja_pkg::PROD_W'(rw_r) * fsja_pkg::PROD_W'(t_r);
    end
    if (idle_st && is_check && short_hit) begin
      res_accept_r <= 1'b1;
      res_cause_r  <= short_cause;
    end else if (eval_st) begin
      res_accept_r <= eval_accept;
      res_cause_r  <= eval_accept ? fsja_pkg::CAUSE_RAND_ACCEPT : fsja_pkg::CAUSE_RAND_REJECT;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_st && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_st && out_free) begin
      out_accept_r <= res_accept_r;
      out_cause_r  <= res_cause_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accept         = out_accept_r;
  assign out_decision_cause = out_cause_r;

endmodule

/* design/fsja_cell.sv */
// ----------------------------------------------------------------------------
// fsja_cell
// one history slot: holds a job time and folds it into the passing minimum
// ----------------------------------------------------------------------------
module fsja_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic                       use_en,
  input  logic [fsja_pkg::TIME_W-1:0] time_in,
  output logic [fsja_pkg::TIME_W-1:0] time_out,
  input  logic [fsja_pkg::TIME_W-1:0] min_in,
  output logic [fsja_pkg::TIME_W-1:0] min_out
);

  logic [fsja_pkg::TIME_W-1:0] time_r;
  logic [fsja_pkg::TIME_W-1:0] min_r;
  logic [fsja_pkg::TIME_W-1:0] min_nxt;

  // slot only counts when it lies inside the kept window
  assign min_nxt = (use_en && (time_r < min_in)) ? time_r : min_in;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      time_r <= time_in;
    end
    min_r <= min_nxt;
  end

  assign time_out = time_r;
  assign min_out  = min_r;

endmodule

/* design/fsja_chain.sv */
// ----------------------------------------------------------------------------
// fsja_chain
// row of history cells with the fill count; newest time enters at cell zero
// ----------------------------------------------------------------------------
module fsja_chain #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               record_en,
  input  logic [fsja_pkg::TIME_W-1:0]        record_time,
  input  logic [fsja_pkg::HLEN_W-1:0]        history_length,
  input  logic [fsja_pkg::TIME_W-1:0]        fallback_time,
  output logic [fsja_pkg::TIME_W-1:0]        min_out
);

  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LW = (CW > fsja_pkg::HLEN_W) ? CW : fsja_pkg::HLEN_W;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [LW-1:0] hlen_ext;
  logic [LW-1:0] len_clamped;
  logic [CW-1:0] kept_len;

  logic [fsja_pkg::TIME_W-1:0] time_link [HISTORY_DEPTH+1];
  logic [fsja_pkg::TIME_W-1:0] min_link  [HISTORY_DEPTH+1];

  // kept length clamped to 1..depth
  assign hlen_ext    = LW'(history_length);
  assign len_clamped = (hlen_ext == '0) ? LW'(1) :
                       ((hlen_ext > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : hlen_ext);
  assign kept_len    = CW'(len_clamped);

  assign count_nxt = (count_r < kept_len) ? (count_r + CW'(1)) : kept_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (record_en) begin
      count_r <= count_nxt;
    end
  end

  // an empty window falls back to the job time itself
  assign time_link[0] = record_time;
  assign min_link[0]  = (count_r == '0) ? fallback_time : {fsja_pkg::TIME_W{1'b1}};

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    fsja_cell u_cell (
      .clk      (clk),
      .shift_en (record_en),
      .use_en   (count_r > CW'(g)),
      .time_in  (time_link[g]),
      .time_out (time_link[g+1]),
      .min_in   (min_link[g]),
      .min_out  (min_link[g+1])
    );
  end

  assign min_out = min_link[HISTORY_DEPTH];

endmodule
